@@ sv/rlce_pkg.sv @@
// ----------------------------------------------------------------------------
// rlce_pkg
// Shared types and constants for the run-length cross erosion block.
// ----------------------------------------------------------------------------
package rlce_pkg;

    localparam int MAX_RUNS_DEF = 16;
    localparam int MAX_COLS_DEF = 4096;
    localparam int COL_W        = 12;
    localparam int RUN_W        = 2 * COL_W;
    localparam int MAX_OUT      = 46;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT_RD,
        ST_INT_CMP,
        ST_ERO_RD,
        ST_ERO_CMP,
        ST_EMPTY,
        ST_LAST,
        ST_FIN
    } state_t;

    // Result item handed from the engine to the output register.
    typedef struct packed {
        logic [COL_W-1:0] left;
        logic [COL_W-1:0] right;
        logic             has_run;
        logic             line_end;
        logic             frame_end;
        logic             overflow;
    } res_t;

endpackage

@@ sv/rlce_line_mem.sv @@
// ----------------------------------------------------------------------------
// rlce_line_mem
// Run store: three line slots of MAX_RUNS runs plus the vertical run buffer.
// Registered reads: two line ports, one vertical; one write port each.
// ----------------------------------------------------------------------------
module rlce_line_mem #(
    parameter int MAX_RUNS = rlce_pkg::MAX_RUNS_DEF
) (
    input  logic                                  clk,
    input  logic                                  line_we,
    input  logic [$clog2(3*MAX_RUNS)-1:0]         line_waddr,
    input  logic [rlce_pkg::RUN_W-1:0]            line_wdata,
    input  logic [$clog2(3*MAX_RUNS)-1:0]         line_raddr_a,
    input  logic [$clog2(3*MAX_RUNS)-1:0]         line_raddr_b,
    output logic [rlce_pkg::RUN_W-1:0]            line_rdata_a,
    output logic [rlce_pkg::RUN_W-1:0]            line_rdata_b,
    input  logic                                  vert_we,
    input  logic [$clog2(2*MAX_RUNS)-1:0]         vert_waddr,
    input  logic [rlce_pkg::RUN_W-1:0]            vert_wdata,
    input  logic [$clog2(2*MAX_RUNS)-1:0]         vert_raddr,
    output logic [rlce_pkg::RUN_W-1:0]            vert_rdata
);
    import rlce_pkg::*;

    localparam int LDEPTH = 3 * MAX_RUNS;
    localparam int VDEPTH = 2 * MAX_RUNS;

    logic [RUN_W-1:0] line_mem [LDEPTH];
    logic [RUN_W-1:0] vert_mem [VDEPTH];

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        line_rdata_a <= line_mem[line_raddr_a];
        line_rdata_b <= line_mem[line_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (vert_we)
        begin
            vert_mem[vert_waddr] <= vert_wdata;
        end
        vert_rdata <= vert_mem[vert_raddr];
    end

endmodule

@@ sv/run_length_cross_erosion.sv @@
// ----------------------------------------------------------------------------
// run_length_cross_erosion
// Plus-shaped binary erosion of a run-coded image.
//
// Input items arrive on s_axis: one run per item, sorted by column, tlast on
// the last item of a line and tuser set on that item when the line is the
// last of the frame. An item without a run (has_run low) marks an empty line.
// Results leave on m_axis: the eroded runs of the middle line, columns
// shifted one to the left, or one empty marker per line; tlast closes an
// output line and tuser holds {overflow, frame_end}.
// A run item that does not close a line is taken with a single memory
// write. From the third line of a frame on, a line-closing item starts
// the merge: the above/below intersection runs over up to 2*MAX_RUNS-1
// read and compare steps, then the erosion pass, each step waiting for
// the synchronous read of the run memory. Each surviving run is held back
// one step so the last one of the line leaves with tlast set. s_axis is held
// off while a line is merged and until its last result is taken; a stalled
// receiver holds the merge in place.
// After reset all counts are zero and the next item starts a new frame.
// ----------------------------------------------------------------------------
module run_length_cross_erosion #(
    parameter int MAX_RUNS = rlce_pkg::MAX_RUNS_DEF,
    parameter int MAX_COLS = rlce_pkg::MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // run_left[11:0], run_right[23:12], has_run[24]
    input  logic        s_axis_tlast,  // line_end
    input  logic        s_axis_tuser,  // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_left[11:0], out_right[23:12], out_has_run[24]
    output logic        m_axis_tlast,  // out_line_end
    output logic [1:0]  m_axis_tuser   // out_frame_end[0], overflow[1]
);
    import rlce_pkg::*;

    localparam int LAW = $clog2(3 * MAX_RUNS);
    localparam int VAW = $clog2(2 * MAX_RUNS);
    localparam int CW  = $clog2(MAX_RUNS + 1);
    localparam int VCW = $clog2(2 * MAX_RUNS + 1);
    localparam int OCW = $clog2(MAX_OUT + 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLS - 1);

    state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg [3];
    logic [CW-1:0]  cnt_next [3];
    logic [1:0]     seen_reg, seen_next;
    logic [1:0]     slot_reg, slot_next;
    logic           ovf_reg, ovf_next;
    logic           fe_reg, fe_next;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next;
    logic [VCW-1:0] vj_reg, vj_next, nv_reg, nv_next;
    logic [OCW-1:0] k_reg, k_next;
    logic           ov_reg, ov_next;
    res_t           out_reg, out_next;
    res_t           pend_reg, pend_next;

    logic           line_we, vert_we;
    logic [LAW-1:0] line_waddr, raddr_a, raddr_b;
    logic [RUN_W-1:0] line_wdata, rdata_a, rdata_b, vert_wdata, vert_rdata;
    logic [VAW-1:0] vert_waddr, vert_raddr;

    rlce_line_mem #(.MAX_RUNS(MAX_RUNS)) u_mem (
        .clk(clk),
        .line_we(line_we), .line_waddr(line_waddr), .line_wdata(line_wdata),
        .line_raddr_a(raddr_a), .line_raddr_b(raddr_b),
        .line_rdata_a(rdata_a), .line_rdata_b(rdata_b),
        .vert_we(vert_we), .vert_waddr(vert_waddr), .vert_wdata(vert_wdata),
        .vert_raddr(vert_raddr), .vert_rdata(vert_rdata)
    );

    logic [1:0] s_above, s_mid, s_next;
    logic [COL_W-1:0] in_l, in_r;
    logic in_has, in_le, in_fe, s_fire, out_free;

    // Compare values (signed, one bit of headroom).
    logic signed [COL_W+1:0] pl, pr, ql, qr, il, ir;
    logic signed [COL_W+1:0] ml, mr, vl, vr, el, ehi;
    logic adv_mid;

    function automatic logic [COL_W-1:0] clampc(input logic [COL_W-1:0] v);
        clampc = (v > COL_MAX) ? COL_MAX : v;
    endfunction

    function automatic logic [LAW-1:0] addr(input logic [1:0] s, input logic [CW-1:0] i);
        addr = LAW'(32'(s) * MAX_RUNS + 32'(i));
    endfunction

    assign s_above = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
    assign s_mid   = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign s_next  = s_above;

    assign in_l   = clampc(s_axis_tdata[11:0]);
    assign in_r   = clampc(s_axis_tdata[23:12]);
    assign in_has = s_axis_tdata[24];
    assign in_le  = s_axis_tlast;
    assign in_fe  = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {7'd0, out_reg.has_run, out_reg.right, out_reg.left};
    assign m_axis_tlast  = out_reg.line_end;
    assign m_axis_tuser  = {out_reg.overflow, out_reg.frame_end};

    assign pl = {2'b00, rdata_a[COL_W-1:0]};
    assign pr = {2'b00, rdata_a[RUN_W-1:COL_W]};
    assign ql = {2'b00, rdata_b[COL_W-1:0]};
    assign qr = {2'b00, rdata_b[RUN_W-1:COL_W]};
    assign il = (pl > ql) ? pl : ql;
    assign ir = (pr < qr) ? pr : qr;

    assign ml  = {2'b00, rdata_a[COL_W-1:0]};
    assign mr  = {2'b00, rdata_a[RUN_W-1:COL_W]} - 14'sd2;
    assign vl  = {2'b00, vert_rdata[COL_W-1:0]} - 14'sd1;
    assign vr  = {2'b00, vert_rdata[RUN_W-1:COL_W]} - 14'sd1;
    assign el  = (ml > vl) ? ml : vl;
    assign adv_mid = mr < vr;
    assign ehi = adv_mid ? mr : vr;

    always_comb
    begin
        state_next = state_reg;
        for (int s = 0; s < 3; s++)
        begin
            cnt_next[s] = cnt_reg[s];
        end
        seen_next = seen_reg;
        slot_next = slot_reg;
        ovf_next  = ovf_reg;
        fe_next   = fe_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        vj_next   = vj_reg;
        nv_next   = nv_reg;
        k_next    = k_reg;
        ov_next   = ov_reg && !m_axis_tready;
        out_next  = out_reg;
        pend_next = pend_reg;
        line_we    = 1'b0;
        line_waddr = addr(slot_reg, cnt_reg[slot_reg]);
        line_wdata = {in_r, in_l};
        vert_we    = 1'b0;
        vert_waddr = VAW'(nv_reg);
        vert_wdata = {ir[COL_W-1:0], il[COL_W-1:0]};
        raddr_a    = addr(s_above, i_reg);
        raddr_b    = addr(slot_reg, j_reg);
        vert_raddr = VAW'(vj_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_has)
                    begin
                        if (cnt_reg[slot_reg] < CW'(MAX_RUNS))
                        begin
                            line_we = 1'b1;
                            cnt_next[slot_reg] = cnt_reg[slot_reg] + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (in_le)
                    begin
                        fe_next = in_fe;
                        i_next  = '0;
                        j_next  = '0;
                        nv_next = '0;
                        vj_next = '0;
                        k_next  = '0;
                        if (seen_reg < 2'd2)
                        begin
                            seen_next = seen_reg + 2'd1;
                            state_next = in_fe ? ST_EMPTY : ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_INT_RD;
                        end
                    end
                end
            end
            ST_INT_RD:
            begin
                if (i_reg < cnt_reg[s_above] && j_reg < cnt_reg[slot_reg])
                begin
                    state_next = ST_INT_CMP;
                end
                else
                begin
                    i_next = '0;
                    state_next = ST_ERO_RD;
                end
            end
            ST_INT_CMP:
            begin
                if (ir >= il && nv_reg < VCW'(2 * MAX_RUNS))
                begin
                    vert_we = 1'b1;
                    nv_next = nv_reg + 1'b1;
                end
                if (pr == qr)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
                else if (pr > qr)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
                state_next = ST_INT_RD;
            end
            ST_ERO_RD:
            begin
                raddr_a = addr(s_mid, i_reg);
                if (i_reg < cnt_reg[s_mid] && vj_reg < nv_reg)
                begin
                    state_next = ST_ERO_CMP;
                end
                else
                begin
                    state_next = (k_reg == '0) ? ST_EMPTY : ST_LAST;
                end
            end
            ST_ERO_CMP:
            begin
                raddr_a = addr(s_mid, i_reg);
                if (el <= ehi && k_reg < OCW'(MAX_OUT))
                begin
                    // Hold the newest run back; push the previous one out first.
                    if (k_reg == '0 || out_free)
                    begin
                        if (k_reg != '0)
                        begin
                            ov_next  = 1'b1;
                            out_next = pend_reg;
                        end
                        pend_next.left      = el[COL_W-1:0];
                        pend_next.right     = ehi[COL_W-1:0];
                        pend_next.has_run   = 1'b1;
                        pend_next.line_end  = 1'b0;
                        pend_next.frame_end = 1'b0;
                        pend_next.overflow  = ovf_reg;
                        k_next = k_reg + 1'b1;
                        if (adv_mid) i_next = i_reg + 1'b1;
                        else vj_next = vj_reg + 1'b1;
                        state_next = ST_ERO_RD;
                    end
                end
                else
                begin
                    if (adv_mid) i_next = i_reg + 1'b1;
                    else vj_next = vj_reg + 1'b1;
                    state_next = ST_ERO_RD;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    out_next.left      = '0;
                    out_next.right     = '0;
                    out_next.has_run   = 1'b0;
                    out_next.line_end  = 1'b1;
                    out_next.frame_end = fe_reg;
                    out_next.overflow  = ovf_reg;
                    state_next = ST_FIN;
                end
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    out_next = pend_reg;
                    out_next.line_end  = 1'b1;
                    out_next.frame_end = fe_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                k_next = '0;
                if (fe_reg)
                begin
                    for (int s = 0; s < 3; s++)
                    begin
                        cnt_next[s] = '0;
                    end
                    seen_next = '0;
                    slot_next = '0;
                    ovf_next  = 1'b0;
                end
                else
                begin
                    slot_next = s_next;
                    cnt_next[s_next] = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int s = 0; s < 3; s++)
            begin
                cnt_reg[s] <= '0;
            end
            seen_reg <= '0;
            slot_reg <= '0;
            ovf_reg  <= 1'b0;
            ov_reg   <= 1'b0;
            fe_reg   <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            vj_reg   <= '0;
            nv_reg   <= '0;
            k_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            slot_reg  <= slot_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            fe_reg    <= fe_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            vj_reg    <= vj_next;
            nv_reg    <= nv_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

@@ tb/run_length_cross_erosion_test.sv @@
// ----------------------------------------------------------------------------
// run_length_cross_erosion_test
// Self-checking bench for the run-length cross erosion block.
//
// Sends lines of sorted runs, empty lines, short frames, overfull lines and
// random unsorted runs. A built-in model of the erosion predicts each result
// item, and every item leaving the block is checked against the oldest
// prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module run_length_cross_erosion_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rlce_pkg::*;

    localparam int NRUNS = MAX_RUNS_DEF;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        int l;
        int r;
    } span_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // model state
    span_t ring_runs[3][NRUNS];
    int    ring_cnt[3];
    span_t vert_runs[2*NRUNS];
    int    closed_lines;
    int    fill_slot;
    bit    dropped;

    res_t  eroded_q[$];
    int    n_err;
    int    n_items;
    int    n_results;
    int    idle_cycles;
    bit    rx_idle_en;

    run_length_cross_erosion u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int want);
        n_err++;
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    endtask

    function automatic void push_res(int l, int r, bit has);
        res_t x;
        x.left = l[11:0];
        x.right = r[11:0];
        x.has_run = has;
        x.line_end = 1'b0;
        x.frame_end = 1'b0;
        x.overflow = dropped;
        eroded_q.push_back(x);
    endfunction

    function automatic void predict_erosion(int l, int r, bit has, bit le, bit fe);
        int s, mid, above, nv, i, j, k, m, n, lo, hi, vl, vr, rr, cnt;
        bit adv;
        res_t x;
        s = fill_slot;
        cnt = 0;
        if (has)
        begin
            if (ring_cnt[s] < NRUNS)
            begin
                ring_runs[s][ring_cnt[s]] = '{l, r};
                ring_cnt[s]++;
            end
            else
                dropped = 1'b1;
        end
        if (!le)
            return;
        if (closed_lines < 2)
        begin
            closed_lines++;
            if (fe)
            begin
                push_res(0, 0, 1'b0);
                cnt = 1;
            end
        end
        else
        begin
            mid = (s + 2) % 3;
            above = (s + 1) % 3;
            i = 0; j = 0; nv = 0;
            m = ring_cnt[above];
            n = ring_cnt[s];
            while (i < m && j < n)
            begin
                lo = ring_runs[above][i].l > ring_runs[s][j].l ?
                     ring_runs[above][i].l : ring_runs[s][j].l;
                hi = ring_runs[above][i].r < ring_runs[s][j].r ?
                     ring_runs[above][i].r : ring_runs[s][j].r;
                if (hi >= lo && nv < 2*NRUNS)
                begin
                    vert_runs[nv] = '{lo, hi};
                    nv++;
                end
                if (ring_runs[above][i].r == ring_runs[s][j].r)
                begin
                    i++; j++;
                end
                else if (ring_runs[above][i].r > ring_runs[s][j].r)
                    j++;
                else
                    i++;
            end
            i = 0; j = 0; k = 0;
            m = ring_cnt[mid];
            while (i < m && j < nv)
            begin
                rr = ring_runs[mid][i].r - 2;
                vl = vert_runs[j].l - 1;
                vr = vert_runs[j].r - 1;
                lo = ring_runs[mid][i].l > vl ? ring_runs[mid][i].l : vl;
                adv = rr < vr;
                hi = adv ? rr : vr;
                if (lo <= hi && k < MAX_OUT)
                begin
                    push_res(lo, hi, 1'b1);
                    k++;
                end
                if (adv)
                    i++;
                else
                    j++;
            end
            if (k == 0)
            begin
                push_res(0, 0, 1'b0);
                k = 1;
            end
            cnt = k;
        end
        if (cnt > 0)
        begin
            x = eroded_q[$];
            x.line_end = 1'b1;
            x.frame_end = fe;
            eroded_q[$] = x;
        end
        if (fe)
        begin
            ring_cnt = '{0, 0, 0};
            closed_lines = 0;
            fill_slot = 0;
            dropped = 1'b0;
        end
        else
        begin
            fill_slot = (s + 1) % 3;
            ring_cnt[fill_slot] = 0;
        end
    endfunction

    // Send one item after a random gap and fold it into the model.
    // tvalid stays high after the accepting edge; the next call or a drain
    // drops it in the same time step.
    task automatic send_item(int l, int r, bit has, bit le, bit fe);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, has, r[11:0], l[11:0]};
        s_axis_tlast <= le;
        s_axis_tuser <= fe;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
        predict_erosion(l, r, has, le, fe);
    endtask

    // One line of sorted runs, sizes kept mostly small.
    task automatic send_line(int nr, bit fe, int base, int maxw);
        int c, w, k;
        c = base;
        if (nr == 0)
        begin
            send_item($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 1'b1, fe);
            return;
        end
        for (k = 0; k < nr; k++)
        begin
            c = c + $urandom_range(0, 4);
            w = $urandom_range(0, maxw);
            if (c + w > 4095)
                c = 4095 - w;
            send_item(c, c + w, 1'b1, k == nr - 1, fe);
            c = c + w + 1;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (eroded_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic test_directed();
        // field extremes on a single full-width frame
        send_item(0, 4095, 1'b1, 1'b1, 1'b0);
        send_item(0, 4095, 1'b1, 1'b1, 1'b0);
        send_item(4095, 4095, 1'b0, 1'b0, 1'b1);
        send_item(0, 4095, 1'b1, 1'b1, 1'b1);
        // short frames: one line, two lines, empty lines
        send_item(5, 9, 1'b1, 1'b1, 1'b1);
        send_item(0, 0, 1'b0, 1'b1, 1'b0);
        send_item(4095, 0, 1'b0, 1'b1, 1'b1);
        // reversed run and 3-line block of rectangles
        send_item(30, 20, 1'b1, 1'b1, 1'b0);
        send_item(10, 40, 1'b1, 1'b1, 1'b0);
        send_item(12, 38, 1'b1, 1'b1, 1'b0);
        send_item(0, 4095, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_overflow();
        send_line(NRUNS + 3, 1'b0, 0, 6);
        send_line(NRUNS + 2, 1'b0, 0, 6);
        send_line(NRUNS, 1'b0, 0, 6);
        send_line(3, 1'b1, 0, 100);
    endtask

    task automatic test_drain_pause();
        send_line(2, 1'b0, 0, 200);
        send_line(2, 1'b0, 0, 200);
        send_line(2, 1'b0, 0, 200);
        wait_drained();
        send_line(1, 1'b1, 0, 300);
    endtask

    task automatic test_random();
        int nl, ln, nr;
        while (n_items < 225)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: run items in no order
                send_item($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 1));
            end
            else
            begin
                nl = $urandom_range(1, 7);
                for (ln = 0; ln < nl; ln++)
                begin
                    nr = $urandom_range(0, 4);
                    if ($urandom_range(0, 15) == 0)
                        nr = NRUNS + 1;
                    send_line(nr, ln == nl - 1, $urandom_range(0, 40),
                              $urandom_range(0, 1) ? 12 : 600);
                end
            end
            rx_idle_en = $urandom_range(0, 3) != 0;
        end
    endtask

    // receiver stall
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle_en ? $urandom_range(0, 7) : 0;
            m_axis_tready <= stall == 0;
            @(posedge clk);
            if (stall != 0)
            begin
                repeat (stall - 1) @(posedge clk);
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (eroded_q.size() == 0)
                    report("unexpected result", m_axis_tdata[11:0], -1);
                else
                begin
                    want = eroded_q.pop_front();
                    if (m_axis_tdata[11:0] != want.left)
                        report("out_left", m_axis_tdata[11:0], want.left);
                    if (m_axis_tdata[23:12] != want.right)
                        report("out_right", m_axis_tdata[23:12], want.right);
                    if (m_axis_tdata[24] != want.has_run)
                        report("out_has_run", m_axis_tdata[24], want.has_run);
                    if (m_axis_tlast != want.line_end)
                        report("out_line_end", m_axis_tlast, want.line_end);
                    if (m_axis_tuser[0] != want.frame_end)
                        report("out_frame_end", m_axis_tuser[0], want.frame_end);
                    if (m_axis_tuser[1] != want.overflow)
                        report("overflow", m_axis_tuser[1], want.overflow);
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", WD_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        rx_idle_en = 1'b1;
        n_err = 0;
        n_items = 0;
        n_results = 0;
        idle_cycles = 0;
        ring_cnt = '{0, 0, 0};
        closed_lines = 0;
        fill_slot = 0;
        dropped = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_drain_pause();
        test_random();
        // close any open frame so its results drain
        send_item(0, 0, 1'b0, 1'b1, 1'b1);
        wait_drained();
        $display("Sent %0d run items, checked %0d result items.", n_items, n_results);
        $display("Covered short frames, empty lines, overfull lines and random runs.");
        if (n_err == 0 && eroded_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
